// ===== rtl/ptd_pkg.sv =====
// Package for the priority task dispatcher: payload structs, command codes,
// queue geometry and the heap entry ordering function. No dependencies.
package ptd_pkg;

  localparam int NUM_CPUS    = 16;
  localparam int QUEUE_DEPTH = 256;
  localparam int POLL_DEPTH  = 16;
  localparam int CPU_W       = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int PC_W        = $clog2(POLL_DEPTH + 1);
  localparam int PA_W        = $clog2(POLL_DEPTH);
  localparam int ENT_W       = 64;
  localparam int SUCC_W      = 32;

  localparam logic [2:0] KIND_ADD      = 3'd0;
  localparam logic [2:0] KIND_GET      = 3'd1;
  localparam logic [2:0] KIND_POLL     = 3'd2;
  localparam logic [2:0] KIND_RELEASE  = 3'd3;
  localparam logic [2:0] KIND_DISABLE  = 3'd4;
  localparam logic [2:0] KIND_QUERY    = 3'd5;
  localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

  localparam logic [1:0] HINT_OTHER     = 2'd0;
  localparam logic [1:0] HINT_CHILD     = 2'd1;
  localparam logic [1:0] HINT_UNBLOCKED = 2'd2;
  localparam logic [1:0] HINT_BUSY      = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        task_id;
    logic signed [15:0] priority_req;
    logic [1:0]         hint;
    logic [3:0]         cpu;
    logic               has_cpu;
    logic               want_idle;
    logic               may_idle;
    logic               force_req;
  } cmd_t;

  typedef struct packed {
    logic        task_valid;
    logic [15:0] out_task;
    logic [3:0]  target_cpu;
    logic        wake_idle_cpu;
    logic        cpu_goes_idle;
    logic        accepted;
    logic        overflow;
  } rsp_t;

  // Entry a is served before entry b.
  function automatic logic served_before(input logic [ENT_W-1:0] a,
                                         input logic [ENT_W-1:0] b);
    logic signed [15:0] pa;
    logic signed [15:0] pb;
    logic [31:0]        d;
    pa = a[63:48];
    pb = b[63:48];
    d  = b[47:16] - a[47:16];
    if (pa != pb) begin
      served_before = pa > pb;
    end else begin
      served_before = (d != 32'd0) && !d[31];
    end
  endfunction

endpackage

// ===== rtl/priority_task_dispatcher_unit.sv =====
// Top level of the priority task dispatcher: command sequencer, successor
// slots, polling FIFO and two heap instances. Depends on ptd_pkg, ptd_heap.
//
//   channel | direction | beat      | handshake
//   in_     | input     | cmd_t     | in_valid / in_stall
//   out_    | output    | rsp_t     | out_valid / out_stall
//
// One command is taken at a time; each yields one result beat.
// A command without queue work passes from S_IDLE through S_DECIDE and S_OUT
// back to S_IDLE. A push climbs the heap and a pop descends it, one level at
// a time; the sequencer waits in S_PUSH_W or S_POP_W until both heaps idle.
// Reset clears all counts, slot valid bits and the insertion sequence.
// in_stall stays high from acceptance until the result beat is taken.
module priority_task_dispatcher_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ptd_pkg::cmd_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ptd_pkg::rsp_t   out_data
);
  import ptd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_PUSH, S_PUSH_W, S_POP, S_POP_W, S_OUT
  } state_t;

  state_t state_r;
  cmd_t   cmd_r;
  rsp_t   rsp_r;

  logic [NUM_CPUS-1:0] succ_valid_r;
  logic [SUCC_W-1:0]   succ_entry_r [NUM_CPUS];
  logic [CPU_W-1:0]    poll_r [POLL_DEPTH];
  logic [PC_W-1:0]     poll_count_r;
  logic [31:0]         seq_r;

  logic             push_rdy_r;
  logic             push_unb_r;
  logic [31:0]      push_prio_tag_r;
  logic             pop_unb_r;
  logic             do_pop_r;

  logic             rp_push, up_push, rp_pop, up_pop;
  logic             rp_busy, up_busy;
  logic [ENT_W-1:0] rp_top, up_top, push_ent;
  logic [QC_W-1:0]  rp_cnt, up_cnt;

  logic             cpu_ok;
  logic [CPU_W-1:0] ci;
  logic             have_succ;
  logic signed [15:0] sp, up, rp, best;
  logic [1:0]       src;
  logic             rel_hit;
  logic [PA_W-1:0]  rel_idx;

  assign push_ent = {push_prio_tag_r[31:16], seq_r, push_prio_tag_r[15:0]};
  assign rp_push  = state_r == S_PUSH && !push_unb_r;
  assign up_push  = state_r == S_PUSH && push_unb_r;
  assign rp_pop   = state_r == S_POP && !pop_unb_r;
  assign up_pop   = state_r == S_POP && pop_unb_r;

  ptd_heap u_ready (
    .clk(clk), .rst_n(rst_n), .push(rp_push), .pop(rp_pop), .push_ent(push_ent),
    .busy(rp_busy), .top(rp_top), .count(rp_cnt)
  );
  ptd_heap u_unblk (
    .clk(clk), .rst_n(rst_n), .push(up_push), .pop(up_pop), .push_ent(push_ent),
    .busy(up_busy), .top(up_top), .count(up_cnt)
  );

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_data  = rsp_r;

  assign cpu_ok    = 32'(cmd_r.cpu) < NUM_CPUS;
  assign ci        = cmd_r.cpu;
  assign have_succ = cpu_ok && succ_valid_r[ci];
  assign sp        = succ_entry_r[ci][31:16];
  assign up        = up_top[63:48];
  assign rp        = rp_top[63:48];

  always_comb begin
    src  = 2'd0;
    best = sp;
    if (have_succ) src = 2'd1;
    if (up_cnt != '0 && (src == 2'd0 || best < up)) begin
      src  = 2'd2;
      best = up;
    end
    if (rp_cnt != '0 && (src == 2'd0 || best < rp)) begin
      src = 2'd3;
    end
  end

  always_comb begin
    rel_hit = 1'b0;
    rel_idx = '0;
    for (int i = POLL_DEPTH - 1; i >= 0; i--) begin
      if (PC_W'(i) < poll_count_r && poll_r[i] == ci) begin
        rel_hit = 1'b1;
        rel_idx = PA_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      succ_valid_r <= '0;
      poll_count_r <= '0;
      seq_r        <= '0;
      do_pop_r     <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_data;
            rsp_r   <= '0;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          case (cmd_r.kind)
            KIND_ADD: begin
              if (cmd_r.has_cpu && cpu_ok && cmd_r.hint == HINT_OTHER &&
                  !succ_valid_r[ci]) begin
                succ_valid_r[ci] <= 1'b1;
                succ_entry_r[ci] <= {cmd_r.priority_req, cmd_r.task_id};
                state_r          <= S_OUT;
              end else if (poll_count_r != '0) begin
                rsp_r.task_valid <= 1'b1;
                rsp_r.out_task   <= cmd_r.task_id;
                rsp_r.target_cpu <= poll_r[0];
                for (int i = 0; i < POLL_DEPTH - 1; i++) poll_r[i] <= poll_r[i+1];
                poll_count_r <= poll_count_r - PC_W'(1);
                state_r      <= S_OUT;
              end else begin
                push_unb_r      <= cmd_r.hint == HINT_UNBLOCKED;
                push_prio_tag_r <= {cmd_r.priority_req, cmd_r.task_id};
                if (cmd_r.hint == HINT_UNBLOCKED ? up_cnt == QC_W'(QUEUE_DEPTH)
                                                 : rp_cnt == QC_W'(QUEUE_DEPTH)) begin
                  rsp_r.overflow <= 1'b1;
                  state_r        <= S_OUT;
                end else begin
                  rsp_r.wake_idle_cpu <= cmd_r.want_idle;
                  state_r             <= S_PUSH;
                end
              end
            end
            KIND_GET, KIND_POLL: begin
              if (src == 2'd0) begin
                state_r <= S_OUT;
                if (cmd_r.kind == KIND_GET) begin
                  rsp_r.cpu_goes_idle <= cmd_r.may_idle;
                end else if (poll_count_r < PC_W'(POLL_DEPTH)) begin
                  poll_r[poll_count_r[PA_W-1:0]] <= ci;
                  poll_count_r   <= poll_count_r + PC_W'(1);
                  rsp_r.accepted <= 1'b1;
                end
              end else begin
                rsp_r.task_valid <= 1'b1;
                rsp_r.target_cpu <= ci;
                rsp_r.accepted   <= cmd_r.kind == KIND_POLL;
                if (src == 2'd1) begin
                  succ_valid_r[ci] <= 1'b0;
                  rsp_r.out_task   <= succ_entry_r[ci][15:0];
                  state_r          <= S_OUT;
                end else begin
                  rsp_r.out_task <= (src == 2'd3) ? rp_top[15:0] : up_top[15:0];
                  pop_unb_r      <= src == 2'd2;
                  if (have_succ) begin
                    succ_valid_r[ci] <= 1'b0;
                    push_unb_r       <= 1'b0;
                    push_prio_tag_r  <= succ_entry_r[ci];
                    if (rp_cnt == QC_W'(QUEUE_DEPTH)) begin
                      rsp_r.overflow <= 1'b1;
                      state_r        <= S_POP;
                    end else begin
                      do_pop_r <= 1'b1;
                      state_r  <= S_PUSH;
                    end
                  end else begin
                    state_r <= S_POP;
                  end
                end
              end
            end
            KIND_RELEASE: begin
              state_r <= S_OUT;
              if (rel_hit) begin
                for (int i = 0; i < POLL_DEPTH - 1; i++) begin
                  if (PA_W'(i) >= rel_idx) poll_r[i] <= poll_r[i+1];
                end
                poll_count_r        <= poll_count_r - PC_W'(1);
                rsp_r.accepted      <= 1'b1;
                rsp_r.cpu_goes_idle <= cmd_r.may_idle;
              end
            end
            KIND_DISABLE: begin
              if (have_succ) begin
                succ_valid_r    <= succ_valid_r & ~(NUM_CPUS'(1) << ci);
                push_unb_r      <= 1'b0;
                push_prio_tag_r <= succ_entry_r[ci];
                if (rp_cnt == QC_W'(QUEUE_DEPTH)) begin
                  rsp_r.overflow <= 1'b1;
                  state_r        <= S_OUT;
                end else begin
                  state_r <= S_PUSH;
                end
              end else begin
                state_r <= S_OUT;
              end
            end
            KIND_QUERY: begin
              rsp_r.wake_idle_cpu <= cmd_r.force_req || rp_cnt != '0 || up_cnt != '0;
              state_r             <= S_OUT;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_PUSH: begin
          seq_r   <= seq_r + 32'd1;
          state_r <= S_PUSH_W;
        end
        S_PUSH_W: begin
          if (!rp_busy && !up_busy) begin
            state_r  <= do_pop_r ? S_POP : S_OUT;
            do_pop_r <= 1'b0;
          end
        end
        S_POP: state_r <= S_POP_W;
        S_POP_W: begin
          if (!rp_busy && !up_busy) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ptd_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module ptd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/ptd_heap.sv =====
// One max-priority heap held in a single-port RAM, walked one level at a time.
// Depends on ptd_pkg and ptd_ram.
module ptd_heap (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic                       pop,
  input  logic [ptd_pkg::ENT_W-1:0]  push_ent,
  output logic                       busy,
  output logic [ptd_pkg::ENT_W-1:0]  top,
  output logic [ptd_pkg::QC_W-1:0]   count
);
  import ptd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_POP_RDL, S_POP_TOP, S_DN_RDL, S_DN_RDR,
    S_DN_CMP
  } state_t;

  state_t           state_r;
  logic [QC_W-1:0]  count_r;
  logic [QA_W-1:0]  idx_r;
  logic [QA_W-1:0]  par_r;
  logic [ENT_W-1:0] cur_r;
  logic [ENT_W-1:0] top_r;
  logic [ENT_W-1:0] lft_r;
  logic [QC_W:0]    lidx_r;
  logic             we;
  logic [QA_W-1:0]  addr;
  logic [ENT_W-1:0] wdata;
  logic [ENT_W-1:0] rdata;
  logic [ENT_W-1:0] best;
  logic             best_r_sel;

  ptd_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign busy  = state_r != S_IDLE;
  assign top   = top_r;
  assign count = count_r;
  assign best_r_sel = served_before(rdata, lft_r);
  assign best  = best_r_sel ? rdata : lft_r;

  always_comb begin
    we    = 1'b0;
    addr  = idx_r;
    wdata = cur_r;
    case (state_r)
      S_IDLE: begin
        if (push && count_r < QC_W'(QUEUE_DEPTH)) begin
          we    = 1'b1;
          addr  = count_r[QA_W-1:0];
          wdata = push_ent;
        end else if (pop) begin
          addr = QA_W'(count_r - QC_W'(1));
        end
      end
      S_UP_RD:  addr = par_r;
      S_UP_CMP: begin
        if (served_before(cur_r, rdata)) begin
          we    = 1'b1;
          addr  = idx_r;
          wdata = rdata;
        end else begin
          we = 1'b1;
        end
      end
      S_POP_RDL: addr = idx_r;
      S_POP_TOP: addr = lidx_r[QA_W-1:0];
      S_DN_RDL:  addr = QA_W'(lidx_r + 1'b1);
      S_DN_RDR:  addr = idx_r;
      S_DN_CMP: begin
        we    = 1'b1;
        wdata = (lidx_r == '1) ? cur_r : lft_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (push && count_r < QC_W'(QUEUE_DEPTH)) begin
            count_r <= count_r + QC_W'(1);
            cur_r   <= push_ent;
            idx_r   <= count_r[QA_W-1:0];
            if (count_r == '0) begin
              top_r <= push_ent;
            end else begin
              par_r   <= QA_W'((count_r - QC_W'(1)) >> 1);
              state_r <= S_UP_RD;
            end
          end else if (pop) begin
            count_r <= count_r - QC_W'(1);
            idx_r   <= '0;
            state_r <= S_POP_RDL;
          end
        end
        S_UP_RD: state_r <= S_UP_CMP;
        S_UP_CMP: begin
          if (served_before(cur_r, rdata)) begin
            if (par_r == '0) begin
              top_r   <= cur_r;
              idx_r   <= '0;
              state_r <= S_DN_CMP;
              lidx_r  <= '1;
            end else begin
              idx_r   <= par_r;
              par_r   <= QA_W'((par_r - QA_W'(1)) >> 1);
              state_r <= S_UP_RD;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_POP_RDL: begin
          cur_r <= rdata;
          if (count_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            top_r <= rdata;
            if (count_r == QC_W'(1)) begin
              state_r <= S_DN_CMP;
              lidx_r  <= '1;
            end else begin
              lidx_r  <= (QC_W+1)'(1);
              state_r <= S_POP_TOP;
            end
          end
        end
        S_POP_TOP: state_r <= S_DN_RDL;
        S_DN_RDL: begin
          lft_r <= rdata;
          if (lidx_r + 1'b1 < {1'b0, count_r}) begin
            state_r <= S_DN_RDR;
          end else begin
            // Only the left child exists.
            state_r <= S_DN_CMP;
            if (served_before(rdata, cur_r)) begin
              if (idx_r == '0) begin
                top_r <= rdata;
              end
              par_r <= lidx_r[QA_W-1:0];
            end else begin
              lidx_r <= '1;
            end
          end
        end
        S_DN_RDR: begin
          if (served_before(best, cur_r)) begin
            lft_r  <= best;
            par_r  <= best_r_sel ? QA_W'(lidx_r + 1'b1) : lidx_r[QA_W-1:0];
            if (idx_r == '0) begin
              top_r <= best;
            end
          end else begin
            lidx_r <= '1;
          end
          state_r <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (lidx_r == '1) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= par_r;
            if ({1'b0, par_r, 1'b1} < {1'b0, count_r}) begin
              lidx_r  <= {1'b0, par_r, 1'b1};
              state_r <= S_POP_TOP;
            end else begin
              lidx_r <= '1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
